>>> rtl/core/lsd_pkg.sv
// Package for the decimal LSD radix sorter: widths, bucket count, the
// sequencer state type and the digit helper functions. No dependencies.
package lsd_pkg;
  localparam int unsigned DefCapacity = 64;
  localparam int unsigned Radix       = 10;
  localparam int unsigned ValW        = 16;
  localparam int unsigned DigW        = 4;

  typedef enum logic [3:0] {
    ST_LOAD, ST_CLR, ST_HIST, ST_HWAIT, ST_PFX, ST_SCAT, ST_SWAIT, ST_COPY, ST_CWAIT,
    ST_NEXT, ST_EMIT, ST_EWAIT
  } state_e;

  // decimal digit of v selected by pass index p (0..4): scale v by
  // 2^32 / 10^(p+1), keep the fraction and multiply it by ten
  function automatic logic [DigW-1:0] digit_of(input logic [ValW-1:0] v,
                                               input logic [2:0] p);
    logic [28:0] k;
    logic [44:0] prod;
    logic [35:0] frac10;
    case (p)
      3'd0: k = 29'd429496730;
      3'd1: k = 29'd42949673;
      3'd2: k = 29'd4294968;
      3'd3: k = 29'd429497;
      default: k = 29'd42950;
    endcase
    prod = 45'(v) * 45'(k);
    frac10 = 36'({prod[31:0], 3'b000}) + 36'({prod[31:0], 1'b0});
    return frac10[35:32];
  endfunction

  // max / weight(p) != 0
  function automatic logic pass_needed(input logic [ValW-1:0] m, input logic [2:0] p);
    logic r;
    case (p)
      3'd0: r = (m != 16'd0);
      3'd1: r = (m >= 16'd10);
      3'd2: r = (m >= 16'd100);
      3'd3: r = (m >= 16'd1000);
      3'd4: r = (m >= 16'd10000);
      default: r = 1'b0;
    endcase
    return r;
  endfunction
endpackage

>>> rtl/core/lsd_mem.sv
// Simple dual-port synchronous memory with a registered read.
// Uses lsd_pkg for the data width.
module lsd_mem #(
  parameter int unsigned Depth = lsd_pkg::DefCapacity
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [$clog2(Depth)-1:0]   waddr_i,
  input  logic [lsd_pkg::ValW-1:0]   wdata_i,
  input  logic [$clog2(Depth)-1:0]   raddr_i,
  output logic [lsd_pkg::ValW-1:0]   rdata_o
);
  logic [lsd_pkg::ValW-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> rtl/core/lsd_decimal_radix_sort.sv
// Top level of the decimal LSD radix sorter: sequencer, histogram registers
// and two lsd_mem stores. Depends on lsd_pkg and lsd_mem.
//
// Usage: values enter on value_i/last_i with in_valid_i/in_ready_o, one per
// cycle while loading. The transfer with last_i high closes the set; the
// block then sorts and sends every stored value on sorted_value_o with
// out_valid_o/out_ready_i, ascending, last_res_o on the final one and
// overflowed_o on all of them if values past CAPACITY were dropped.
// The sort runs P digit passes (P = decimal digits of the maximum, at most
// 5), and its pace is bounded by the one read port of each store: every
// pass walks the set three times (histogram, scatter, copy back). Emission
// first primes the read of entry 0, and stalls hold the current result in
// the output register.
// in_ready_o is low from the last transfer until the final result leaves.
// Reset clears the sequencer, counters and bucket registers; store contents
// are left undefined and are only read after being written in the set.
module lsd_decimal_radix_sort #(
  parameter int unsigned CAPACITY = lsd_pkg::DefCapacity
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [lsd_pkg::ValW-1:0] value_i,
  input  logic                     last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic [lsd_pkg::ValW-1:0] sorted_value_o,
  output logic                     last_res_o,
  output logic                     overflowed_o
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  lsd_pkg::state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d, idx_q, idx_d;
  logic [lsd_pkg::ValW-1:0] max_q, max_d;
  logic drop_q, drop_d;
  logic [2:0] pass_q, pass_d;
  logic [CW-1:0] bkt_q [lsd_pkg::Radix];
  logic [CW-1:0] bkt_d [lsd_pkg::Radix];
  logic [lsd_pkg::ValW-1:0] out_val_q, out_val_d;
  logic out_vld_q, out_vld_d, out_last_q, out_last_d;

  logic va_we, sc_we;
  logic [AW-1:0] va_wa, va_ra, sc_wa, sc_ra;
  logic [lsd_pkg::ValW-1:0] va_wd, va_rd, sc_rd;
  logic [lsd_pkg::DigW-1:0] dig;

  lsd_mem #(.Depth(CAPACITY)) u_val (
    .clk_i, .we_i(va_we), .waddr_i(va_wa), .wdata_i(va_wd),
    .raddr_i(va_ra), .rdata_o(va_rd));
  lsd_mem #(.Depth(CAPACITY)) u_scr (
    .clk_i, .we_i(sc_we), .waddr_i(sc_wa), .wdata_i(va_rd),
    .raddr_i(sc_ra), .rdata_o(sc_rd));

  assign dig = lsd_pkg::digit_of(va_rd, pass_q);
  assign in_ready_o = (state_q == lsd_pkg::ST_LOAD);
  assign out_valid_o = out_vld_q;
  assign sorted_value_o = out_val_q;
  assign last_res_o = out_last_q;
  assign overflowed_o = drop_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lsd_pkg::ST_LOAD;
      cnt_q <= '0; idx_q <= '0; max_q <= '0; drop_q <= 1'b0; pass_q <= '0;
      out_vld_q <= 1'b0; out_last_q <= 1'b0;
      for (int b = 0; b < lsd_pkg::Radix; b++) bkt_q[b] <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d; idx_q <= idx_d; max_q <= max_d; drop_q <= drop_d;
      pass_q <= pass_d; out_vld_q <= out_vld_d; out_last_q <= out_last_d;
      for (int b = 0; b < lsd_pkg::Radix; b++) bkt_q[b] <= bkt_d[b];
    end
  end

  always_ff @(posedge clk_i) out_val_q <= out_val_d;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; max_d = max_q;
    drop_d = drop_q; pass_d = pass_q; out_vld_d = out_vld_q;
    out_last_d = out_last_q; out_val_d = out_val_q;
    for (int b = 0; b < lsd_pkg::Radix; b++) bkt_d[b] = bkt_q[b];
    va_we = 1'b0; va_wa = cnt_q[AW-1:0]; va_wd = value_i;
    va_ra = idx_q[AW-1:0];
    sc_we = 1'b0; sc_wa = '0; sc_ra = idx_q[AW-1:0];
    unique case (state_q)
      lsd_pkg::ST_LOAD: begin
        if (in_valid_i) begin
          if (cnt_q < CW'(CAPACITY)) begin
            va_we = 1'b1;
            cnt_d = cnt_q + 1'b1;
            if (value_i > max_q) max_d = value_i;
          end else begin
            drop_d = 1'b1;
          end
          if (last_i) begin
            pass_d = '0;
            state_d = lsd_pkg::ST_NEXT;
          end
        end
      end
      lsd_pkg::ST_NEXT: begin
        idx_d = '0;
        if (lsd_pkg::pass_needed(max_q, pass_q)) state_d = lsd_pkg::ST_CLR;
        else state_d = (cnt_q == '0) ? lsd_pkg::ST_LOAD : lsd_pkg::ST_EMIT;
        if (cnt_q == '0 && !lsd_pkg::pass_needed(max_q, pass_q)) begin
          max_d = '0; drop_d = 1'b0;
        end
      end
      lsd_pkg::ST_CLR: begin
        for (int b = 0; b < lsd_pkg::Radix; b++) bkt_d[b] = '0;
        idx_d = '0;
        state_d = lsd_pkg::ST_HIST;
      end
      lsd_pkg::ST_HIST: begin
        // read issued at idx; count the word read last cycle
        if (idx_q != '0) bkt_d[dig] = bkt_q[dig] + 1'b1;
        if (idx_q == cnt_q) state_d = lsd_pkg::ST_PFX;
        else idx_d = idx_q + 1'b1;
      end
      lsd_pkg::ST_PFX: begin
        for (int b = 1; b < lsd_pkg::Radix; b++) bkt_d[b] = bkt_q[b] + bkt_d[b-1];
        idx_d = cnt_q;
        state_d = lsd_pkg::ST_SCAT;
      end
      lsd_pkg::ST_SCAT: begin
        // address idx-1 read, write the word read last cycle
        va_ra = AW'(idx_q - 1'b1);
        if (idx_q != cnt_q) begin
          sc_we = 1'b1;
          sc_wa = AW'(bkt_q[dig] - 1'b1);
          bkt_d[dig] = bkt_q[dig] - 1'b1;
        end
        if (idx_q == '0) begin
          sc_we = 1'b1; sc_wa = AW'(bkt_q[dig] - 1'b1);
          idx_d = '0;
          state_d = lsd_pkg::ST_COPY;
        end else begin
          idx_d = idx_q - 1'b1;
        end
      end
      lsd_pkg::ST_COPY: begin
        sc_ra = idx_q[AW-1:0];
        if (idx_q != '0) begin
          va_we = 1'b1; va_wa = AW'(idx_q - 1'b1); va_wd = sc_rd;
        end
        if (idx_q == cnt_q) begin
          pass_d = pass_q + 1'b1;
          state_d = lsd_pkg::ST_NEXT;
        end else idx_d = idx_q + 1'b1;
      end
      lsd_pkg::ST_EMIT: begin
        // prime read of entry 0
        va_ra = '0;
        idx_d = CW'(1);
        state_d = lsd_pkg::ST_EWAIT;
      end
      lsd_pkg::ST_EWAIT: begin
        if (!out_vld_q || out_ready_i) begin
          out_vld_d = 1'b1;
          out_val_d = va_rd;
          out_last_d = (idx_q == cnt_q);
          va_ra = idx_q[AW-1:0];
          if (idx_q == cnt_q) state_d = lsd_pkg::ST_HWAIT;
          else idx_d = idx_q + 1'b1;
        end else begin
          va_ra = AW'(idx_q - 1'b1);
        end
      end
      lsd_pkg::ST_HWAIT: begin
        // drain final result
        if (out_ready_i) begin
          out_vld_d = 1'b0; out_last_d = 1'b0;
          cnt_d = '0; max_d = '0; drop_d = 1'b0;
          state_d = lsd_pkg::ST_LOAD;
        end
      end
      default: state_d = lsd_pkg::ST_LOAD;
    endcase
  end

  // the scatter sequence above issues a read at idx-1 and consumes the prior
  // word; on entry idx==cnt so the first cycle only issues.

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !in_ready_o)
    else $error("result shown while loading");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> $stable(sorted_value_o))
    else $error("stalled result changed");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("item count above capacity");
endmodule
